// ===== hdl/tpve_pkg.sv =====
// Shared types, constants and helpers of the thick polyline vertex expander.
package tpve_pkg;

  localparam int COORD_W             = 18;
  localparam int COORD_FRAC_BITS_DEF = 14;
  localparam int SAMPLE_W            = 16;
  localparam int XACC_W              = 26;
  localparam int XSTEP_W             = 24;
  localparam int HW_W                = 16;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 24;
  localparam int DIFF_W              = COORD_W + 1;
  localparam int L2_W                = 2 * DIFF_W;
  localparam int RAD_W               = L2_W + 16;
  localparam int SQ_STEPS            = RAD_W / 2;
  localparam int LEN_W               = SQ_STEPS;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic signed [XACC_W-1:0] XACC_START  = -26'sd4194304;
  localparam logic signed [XACC_W-1:0] XACC_MAX    = 26'sd33554431;
  localparam logic signed [17:0]       NINE_TENTHS = 18'sd58982;
  localparam logic [XSTEP_W-1:0]       XSTEP_RST   = 24'd16811;
  localparam logic [HW_W-1:0]          HW_RST      = 16'd137;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THICK  = 2'd0,
    REG_XSTEP  = 2'd1,
    REG_HWIDTH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_A  = 3'd0,
    KIND_B  = 3'd1,
    KIND_AP = 3'd2,
    KIND_AM = 3'd3,
    KIND_BP = 3'd4,
    KIND_BM = 3'd5
  } vkind_e;

  // One queued job: a thin point (in bx/by) or a segment from a to b.
  typedef struct packed {
    logic                      thin;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } seg_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 32'sd131071) begin
      r = 18'sd131071;
    end else if (v < -32'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/tpve_front.sv =====
// Front end: places each sample on screen, tracks the line, queues jobs.
module tpve_front import tpve_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       line_start_i,
  input  logic                       lower_trace_i,
  input  logic                       thick_mode_i,
  input  logic [XSTEP_W-1:0]         x_step_i,
  output logic                       wr_o,
  output seg_t                       seg_o
);

  localparam int XSH = 22 - COORD_FRAC_BITS;
  localparam int YSH = 31 - COORD_FRAC_BITS;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (COORD_FRAC_BITS - 1);

  logic signed [XACC_W-1:0]  x_accum_q, x_accum_d, x_cur;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic                      have_prev_q, have_cur;
  logic signed [XACC_W:0]    x_rnd, x_sh, x_sum;
  logic signed [33:0]        y_prod, y_rnd, y_sh;
  logic signed [COORD_W-1:0] bx, by;

  always_comb begin
    x_cur    = line_start_i ? XACC_START : x_accum_q;
    have_cur = line_start_i ? 1'b0 : have_prev_q;
    x_rnd    = 27'(x_cur) + (27'sd1 <<< (XSH - 1));
    x_sh     = x_rnd >>> XSH;
    bx       = sat_coord(32'(x_sh));
    y_prod   = 34'(sample_i) * 34'(NINE_TENTHS);
    y_rnd    = y_prod + (34'sd1 <<< (YSH - 1));
    y_sh     = y_rnd >>> YSH;
    by       = sat_coord(32'(y_sh) + (lower_trace_i ? -HALF : HALF));
    x_sum    = 27'(x_cur) + $signed({3'b000, x_step_i});
    x_accum_d = (x_sum > 27'(XACC_MAX)) ? XACC_MAX : x_sum[XACC_W-1:0];
  end

  assign wr_o       = accept_i && (!thick_mode_i || have_cur);
  assign seg_o.thin = !thick_mode_i;
  assign seg_o.ax   = prev_x_q;
  assign seg_o.ay   = prev_y_q;
  assign seg_o.bx   = bx;
  assign seg_o.by   = by;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_accum_q   <= XACC_START;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else if (accept_i) begin
      x_accum_q   <= x_accum_d;
      prev_x_q    <= bx;
      prev_y_q    <= by;
      have_prev_q <= 1'b1;
    end
  end

endmodule

// ===== hdl/tpve_fifo.sv =====
// Short job queue between the front end and the back end.
module tpve_fifo import tpve_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  seg_t wdata_i,
  input  logic rd_i,
  output seg_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  seg_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(wr_i) - (PTR_W+1)'(rd_i);
    end
  end

endmodule

// ===== hdl/tpve_back.sv =====
// Back end: segment normal (bit-serial root and divide) and vertex emission.
module tpve_back import tpve_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [HW_W-1:0]           half_width_i,
  input  logic                      q_empty_i,
  input  seg_t                      q_data_i,
  output logic                      q_rd_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic signed [COORD_W-1:0] vert_x_o,
  output logic signed [COORD_W-1:0] vert_y_o,
  output logic [2:0]                vert_kind_o,
  output logic                      last_o
);

  localparam int QW       = COORD_FRAC_BITS + 1;
  localparam int NW       = QW + 1;
  localparam int NUMW     = COORD_FRAC_BITS + 27;
  localparam int PRODW    = (COORD_W) + HW_W;
  localparam int STEPS    = (SQ_STEPS > QW) ? SQ_STEPS : QW;
  localparam int CNT_W    = $clog2(STEPS);
  localparam int REM_W    = LEN_W + 2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  seg_t                     ent_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, sq_src, src;
  logic signed [L2_W-1:0]   sq;
  logic [L2_W-1:0]          l2_q, l2_sum;
  logic [RAD_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [LEN_W-1:0]         root_q;
  logic [REM_W+1:0]         remx, trial;
  logic                     rge;
  logic [CNT_W-1:0]         cnt_q;
  logic [COORD_W-1:0]       amag;
  logic [PRODW-1:0]         prod;
  logic [NUMW-1:0]          num;
  logic                     neg_w, neg_q, comp_q;
  logic [LEN_W-1:0]         divr_q;
  logic [QW-1:0]            dq_q, dq_n;
  logic [LEN_W:0]           dt;
  logic                     dge;
  logic signed [NW-1:0]     nres, nx_q, ny_q;
  vkind_e                   vidx_q;
  logic                     ovalid_q, out_load;
  logic signed [COORD_W-1:0] px, py;

  assign q_rd_o = (state_q == S_IDLE) && !q_empty_i;

  // Shared squarer for the segment length.
  always_comb begin
    sq_src = (state_q == S_SQX) ? dx_q : dy_q;
    sq     = L2_W'(sq_src) * L2_W'(sq_src);
    l2_sum = l2_q + L2_W'(sq);
  end

  // One root digit per cycle.
  always_comb begin
    remx  = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    rge   = (remx >= trial);
  end

  // Numerator of one normal component, with the rounding half-divisor added.
  always_comb begin
    src   = comp_q ? dx_q : dy_q;
    amag  = src[DIFF_W-1] ? COORD_W'(-src) : COORD_W'(src);
    prod  = PRODW'(amag) * PRODW'(half_width_i);
    num   = (NUMW'(prod) << (COORD_FRAC_BITS - 8)) + NUMW'(root_q >> 1);
    neg_w = comp_q ? src[DIFF_W-1] : (!src[DIFF_W-1] && (src != '0));
  end

  // One quotient bit per cycle.
  always_comb begin
    dt   = {divr_q, dq_q[QW-1]};
    dge  = (dt >= {1'b0, root_q});
    dq_n = {dq_q[QW-2:0], dge};
    nres = neg_q ? -$signed(NW'(dq_n)) : $signed(NW'(dq_n));
  end

  // Vertex selection.
  always_comb begin
    px = ent_q.ax;
    py = ent_q.ay;
    if (ent_q.thin) begin
      px = ent_q.bx;
      py = ent_q.by;
    end else begin
      case (vidx_q)
        KIND_A: begin
          px = ent_q.ax;
          py = ent_q.ay;
        end
        KIND_B: begin
          px = ent_q.bx;
          py = ent_q.by;
        end
        KIND_AP: begin
          px = sat_coord(32'(ent_q.ax) + 32'(nx_q));
          py = sat_coord(32'(ent_q.ay) + 32'(ny_q));
        end
        KIND_AM: begin
          px = sat_coord(32'(ent_q.ax) - 32'(nx_q));
          py = sat_coord(32'(ent_q.ay) - 32'(ny_q));
        end
        KIND_BP: begin
          px = sat_coord(32'(ent_q.bx) + 32'(nx_q));
          py = sat_coord(32'(ent_q.by) + 32'(ny_q));
        end
        KIND_BM: begin
          px = sat_coord(32'(ent_q.bx) - 32'(nx_q));
          py = sat_coord(32'(ent_q.by) - 32'(ny_q));
        end
        default: begin
          px = ent_q.ax;
          py = ent_q.ay;
        end
      endcase
    end
  end

  assign out_load = (state_q == S_EMIT) && (!ovalid_q || pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!q_empty_i) state_d = q_data_i.thin ? S_EMIT : S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = (l2_sum == '0) ? S_EMIT : S_ROOT;
      S_ROOT: if (cnt_q == '0) state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (cnt_q == '0) state_d = comp_q ? S_EMIT : S_MUL;
      S_EMIT: if (out_load && (ent_q.thin || vidx_q == KIND_BM)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ent_q  <= q_data_i;
        dx_q   <= DIFF_W'(q_data_i.bx) - DIFF_W'(q_data_i.ax);
        dy_q   <= DIFF_W'(q_data_i.by) - DIFF_W'(q_data_i.ay);
        vidx_q <= KIND_A;
      end
      S_SQX: l2_q <= L2_W'(sq);
      S_SQY: begin
        rad_q  <= {l2_sum, 16'd0};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CNT_W'(SQ_STEPS - 1);
        comp_q <= 1'b0;
        nx_q   <= '0;
        ny_q   <= '0;
      end
      S_ROOT: begin
        rem_q  <= rge ? REM_W'(remx - trial) : REM_W'(remx);
        root_q <= {root_q[LEN_W-2:0], rge};
        rad_q  <= rad_q << 2;
        cnt_q  <= cnt_q - 1'b1;
      end
      S_MUL: begin
        divr_q <= LEN_W'(num >> QW);
        dq_q   <= num[QW-1:0];
        neg_q  <= neg_w;
        cnt_q  <= CNT_W'(QW - 1);
      end
      S_DIV: begin
        divr_q <= dge ? LEN_W'(dt - {1'b0, root_q}) : dt[LEN_W-1:0];
        dq_q   <= dq_n;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (comp_q) ny_q <= nres;
          else        nx_q <= nres;
          comp_q <= 1'b1;
        end
      end
      S_EMIT: if (out_load) vidx_q <= vkind_e'(vidx_q + 3'd1);
      default: ;
    endcase
    if (out_load) begin
      vert_x_o    <= px;
      vert_y_o    <= py;
      vert_kind_o <= ent_q.thin ? KIND_A : vidx_q;
      last_o      <= ent_q.thin || (vidx_q == KIND_BM);
    end
  end

  assign empty_o = !ovalid_q;

endmodule

// ===== hdl/thick_polyline_vertex_expander.sv =====
// Top level of the thick polyline vertex expander: config, front, queue, back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  samples  | push / full            | sample_i, line_start_i, lower_trace_i
//  vertices | pop / empty            | vert_x_o, vert_y_o, vert_kind_o, last_o
//  config   | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// The front end takes one sample per cycle while the two-entry job queue has
// room. A thin point goes from the back end's idle step straight to emit. A
// thick segment is squared (dx, then dy); unless of zero length, it then
// takes a square root (one digit a cycle) and runs the shared divider for x,
// then y (one quotient bit a cycle). A stalled pop holds the back end at emit.
// Reset is asynchronous; no clearing pass is needed.
module thick_polyline_vertex_expander import tpve_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       line_start_i,
  input  logic                       lower_trace_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [COORD_W-1:0]  vert_x_o,
  output logic signed [COORD_W-1:0]  vert_y_o,
  output logic [2:0]                 vert_kind_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i
);

  logic               thick_q;
  logic [XSTEP_W-1:0] xstep_q;
  logic [HW_W-1:0]    hw_q;
  logic               accept;
  logic               fifo_wr, fifo_rd, fifo_full, fifo_empty;
  seg_t               fifo_wdata, fifo_rdata;

  // Configuration registers; a write to an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= 1'b1;
      xstep_q <= XSTEP_RST;
      hw_q    <= HW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THICK:  thick_q <= cfg_wdata_i[0];
        REG_XSTEP:  xstep_q <= cfg_wdata_i[XSTEP_W-1:0];
        REG_HWIDTH: hw_q    <= cfg_wdata_i[HW_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off new samples only while the job queue is full.
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  tpve_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .sample_i      (sample_i),
    .line_start_i  (line_start_i),
    .lower_trace_i (lower_trace_i),
    .thick_mode_i  (thick_q),
    .x_step_i      (xstep_q),
    .wr_o          (fifo_wr),
    .seg_o         (fifo_wdata)
  );

  tpve_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_wr),
    .wdata_i (fifo_wdata),
    .rd_i    (fifo_rd),
    .rdata_o (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  tpve_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (hw_q),
    .q_empty_i    (fifo_empty),
    .q_data_i     (fifo_rdata),
    .q_rd_o       (fifo_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .vert_x_o     (vert_x_o),
    .vert_y_o     (vert_y_o),
    .vert_kind_o  (vert_kind_o),
    .last_o       (last_o)
  );

  // The queue never takes a job while full and never gives one while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_wr |-> !fifo_full)
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_rd |-> !fifo_empty)
    else $error("job queue underflow");
  // A transaction marked last is a thin point or the final corner of a segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && last_o) |-> (vert_kind_o == KIND_A || vert_kind_o == KIND_BM))
    else $error("last flag on a middle vertex");

endmodule
